@@ sv/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tcw_pkg
// Shared types and constants for the text console writer.
// ============================================================================
package tcw_pkg;

    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_SETCUR = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_BLANK  = 6'b010000,
        ST_CLEAR  = 6'b100000
    } state_t;

    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  BLANK_ATTR   = 8'h07;
    localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

endpackage : tcw_pkg
`default_nettype wire

@@ sv/text_console_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// text_console_writer_core
// Text screen of COLS x ROWS cells (character and attribute) with a cursor.
// ============================================================================
// Usage: one request enters on the s_ channel (request kind in s_tuser) and
// exactly one result leaves on the m_ channel, carrying the cursor after the
// request and, for a cell read, the stored character and attribute.
// The screen lives in a single-write, single-read memory of COLS*ROWS cells
// with a registered read port; one address counter walks it for sweeps.
// A put character or set cursor registers its result directly; a cell read
// goes through ST_READ first; a put character that scrolls copies ROWS-1
// rows one cell a cycle in ST_SCROLL, then blanks the bottom row in ST_BLANK;
// clear screen blanks every cell in ST_CLEAR.
// Throughput with m_tready held high: one set-cursor or non-scrolling put
// transaction per cycle.
// Only one request is in work at a time; s_tready is low while a sweep or
// read runs and while an untaken result would be overwritten.
// After reset the block blanks all COLS*ROWS cells (2000 by default) of
// the memory with space and attribute 7, with s_tready low; the cursor is
// at column 0, row 0. A stalled m_tready holds the result and keeps the
// next request out until the result transaction completes.
// ============================================================================
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [15:8] attr_byte, [22:16] pos_col, [27:23] pos_row
    input  wire  [31:0] s_tdata,
    // [1:0] req_type
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [19:12] cell_char, [27:20] cell_attr
    output logic [31:0] m_tdata
);

    localparam int TOTAL = COLS * ROWS;
    localparam int BODY  = (ROWS - 1) * COLS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);

    // Input fields
    logic [7:0] in_char;
    logic [7:0] in_attr;
    logic [6:0] in_col;
    logic [4:0] in_row;
    req_t       in_req;

    assign in_char = s_tdata[7:0];
    assign in_attr = s_tdata[15:8];
    assign in_col  = s_tdata[22:16];
    assign in_row  = s_tdata[27:23];
    assign in_req  = req_t'(s_tuser[1:0]);

    state_t         state_reg, state_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           mvalid_reg, mvalid_next;
    logic [6:0]     ocol_reg, ocol_next;
    logic [4:0]     orow_reg, orow_next;
    logic [7:0]     ochar_reg, ochar_next;
    logic [7:0]     oattr_reg, oattr_next;

    // Screen memory
    logic [15:0]    mem [TOTAL];
    logic [15:0]    rd_data_reg;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [15:0]    wdata;
    logic [AW-1:0]  raddr;

    logic           accept;
    logic [CW-1:0]  sat_col;
    logic [RW-1:0]  sat_row;
    logic [AW-1:0]  sat_addr;
    logic [AW-1:0]  cur_addr;
    logic           last_cell;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign last_cell = (cnt_reg == AW'(TOTAL - 1));

    assign sat_col  = ({2'b00, in_col} > 9'(COLS - 1)) ? CW'(COLS - 1) : CW'(in_col);
    assign sat_row  = ({2'b00, in_row} > 7'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(in_row);
    assign sat_addr = AW'(AW'(sat_row) * AW'(COLS) + AW'(sat_col));
    assign cur_addr = AW'(AW'(row_reg) * AW'(COLS) + AW'(col_reg));

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        mvalid_next = mvalid_reg && !m_tready;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        ochar_next  = ochar_reg;
        oattr_next  = oattr_reg;
        we          = 1'b0;
        waddr       = cnt_reg;
        wdata       = BLANK_CELL;
        raddr       = sat_addr;

        unique case (state_reg)
            ST_INIT: begin
                we       = 1'b1;
                cnt_next = AW'(cnt_reg + 1'b1);
                if (last_cell) begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    ochar_next = '0;
                    oattr_next = '0;
                    unique case (in_req)
                        REQ_PUT: begin
                            if (in_char != NEWLINE_CODE) begin
                                we    = 1'b1;
                                waddr = cur_addr;
                                wdata = {in_attr, in_char};
                            end
                            if (in_char == NEWLINE_CODE || col_reg == CW'(COLS - 1)) begin
                                col_next = '0;
                                if (row_reg == RW'(ROWS - 1)) begin
                                    state_next = ST_SCROLL;
                                    cnt_next   = '0;
                                end else begin
                                    row_next = RW'(row_reg + 1'b1);
                                end
                            end else begin
                                col_next = CW'(col_reg + 1'b1);
                            end
                            if (!(in_char == NEWLINE_CODE || col_reg == CW'(COLS - 1))
                                || row_reg != RW'(ROWS - 1)) begin
                                mvalid_next = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        REQ_SETCUR: begin
                            col_next    = sat_col;
                            row_next    = sat_row;
                            mvalid_next = 1'b1;
                        end
                        REQ_READ: begin
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                    ocol_next = 7'(col_next);
                    orow_next = 5'(row_next);
                end
            end

            ST_READ: begin
                ochar_next  = rd_data_reg[7:0];
                oattr_next  = rd_data_reg[15:8];
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_SCROLL: begin
                // Read runs one cell ahead of the write that copies it up a row.
                if (cnt_reg < AW'(BODY)) begin
                    raddr = AW'(cnt_reg + AW'(COLS));
                end
                if (cnt_reg != '0) begin
                    we    = 1'b1;
                    waddr = AW'(cnt_reg - 1'b1);
                    wdata = rd_data_reg;
                end
                if (cnt_reg == AW'(BODY)) begin
                    state_next = ST_BLANK;
                end else begin
                    cnt_next = AW'(cnt_reg + 1'b1);
                end
            end

            ST_BLANK: begin
                we       = 1'b1;
                cnt_next = AW'(cnt_reg + 1'b1);
                if (last_cell) begin
                    cnt_next    = '0;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_CLEAR: begin
                we       = 1'b1;
                cnt_next = AW'(cnt_reg + 1'b1);
                if (last_cell) begin
                    cnt_next    = '0;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            cnt_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        ochar_reg <= ochar_next;
        oattr_reg <= oattr_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0000, oattr_reg, ochar_reg, orow_reg, ocol_reg};

endmodule : text_console_writer_core
`default_nettype wire
